// File: rtl/core/png_ru_pkg.sv
package png_ru_pkg;

  localparam int unsigned MaxBpp = 8;
  localparam int unsigned BppW   = $clog2(MaxBpp + 1);
  localparam int unsigned IdxW   = (MaxBpp > 1) ? $clog2(MaxBpp) : 1;

  localparam logic [6:0] PixelBitsReset = 7'd8;

  localparam logic [7:0] FiltNone  = 8'd0;
  localparam logic [7:0] FiltSub   = 8'd1;
  localparam logic [7:0] FiltUp    = 8'd2;
  localparam logic [7:0] FiltAvg   = 8'd3;
  localparam logic [7:0] FiltPaeth = 8'd4;

  typedef struct packed {
    logic [7:0] left;
    logic [7:0] upper_left;
  } nbr_t;

  // Bytes per pixel, clamped to the supported range.
  function automatic logic [BppW-1:0] bytes_per_pixel(input logic [6:0] pixel_bits);
    logic [7:0] sum;
    logic [4:0] n;
    sum = {1'b0, pixel_bits} + 8'd7;
    n   = sum[7:3];
    if (n == 5'd0) begin
      n = 5'd1;
    end else if (n > 5'(MaxBpp)) begin
      n = 5'(MaxBpp);
    end
    return BppW'(n);
  endfunction

endpackage

// File: rtl/core/png_ru_pred.sv
module png_ru_pred
  import png_ru_pkg::*;
(
  input  logic [7:0] filtered_i,
  input  logic [7:0] above_i,
  input  logic [7:0] filter_type_i,
  input  nbr_t       nbr_i,
  output logic [7:0] recon_o
);

  logic [7:0] a, b, c;
  logic [8:0] avg_sum;
  logic signed [10:0] pa, pb, pc;
  logic [7:0] paeth;
  logic [7:0] pred;

  assign a = nbr_i.left;
  assign b = above_i;
  assign c = nbr_i.upper_left;

  assign avg_sum = {1'b0, a} + {1'b0, b};

  // Distances from a + b - c to a, b and c.
  always_comb begin
    pa = $signed({3'b000, b}) - $signed({3'b000, c});
    pb = $signed({3'b000, a}) - $signed({3'b000, c});
    pc = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({2'b00, c, 1'b0});
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    if (pc < 0) pc = -pc;
    if (pa <= pb && pa <= pc) begin
      paeth = a;
    end else if (pb <= pc) begin
      paeth = b;
    end else begin
      paeth = c;
    end
  end

  always_comb begin
    case (filter_type_i)
      FiltSub:   pred = a;
      FiltUp:    pred = b;
      FiltAvg:   pred = avg_sum[8:1];
      FiltPaeth: pred = paeth;
      default:   pred = 8'd0;
    endcase
  end

  assign recon_o = filtered_i + pred;

endmodule

// File: rtl/core/png_ru_hist.sv
module png_ru_hist
  import png_ru_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            advance_i,
  input  logic [BppW-1:0] bpp_i,
  input  logic [7:0]      recon_i,
  input  logic [7:0]      above_i,
  input  logic            row_end_i,
  output nbr_t            nbr_o
);

  logic [7:0]      left_q [MaxBpp];
  logic [7:0]      ul_q   [MaxBpp];
  logic [BppW-1:0] count_q, count_d;
  logic [BppW-1:0] tap;
  logic            in_first_pixel;

  assign tap            = bpp_i - BppW'(1);
  assign in_first_pixel = count_q < bpp_i;

  always_comb begin
    if (in_first_pixel) begin
      nbr_o = '0;
    end else begin
      nbr_o.left       = left_q[tap[IdxW-1:0]];
      nbr_o.upper_left = ul_q[tap[IdxW-1:0]];
    end
  end

  always_comb begin
    count_d = count_q;
    if (row_end_i) begin
      count_d = '0;
    end else if (in_first_pixel) begin
      count_d = count_q + BppW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int k = 0; k < MaxBpp; k++) begin
        left_q[k] <= '0;
        ul_q[k]   <= '0;
      end
    end else if (advance_i) begin
      count_q   <= count_d;
      left_q[0] <= recon_i;
      ul_q[0]   <= above_i;
      for (int k = 1; k < MaxBpp; k++) begin
        left_q[k] <= left_q[k-1];
        ul_q[k]   <= ul_q[k-1];
      end
    end
  end

endmodule

// File: rtl/core/png_row_unfilter.sv
// Path: an accepted beat is held in the input register and, once the output
// register is empty or being taken, is loaded into the output register to leave.
// Throughput: one beat per cycle while m_axis_tready stays high, held by the
// single compute stage between the input register and the output register.
// Reset: asynchronous, active low; clears both histories, the first-pixel
// count and the valid flags, and sets pixel_bits to 8.
module png_row_unfilter
  import png_ru_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // filtered_byte [7:0], above_byte [15:8]
  input  logic [7:0]  s_axis_tuser,  // filter_type [7:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // recon_byte [7:0]
  output logic        m_axis_tlast
);

  logic [6:0] pixel_bits_q;
  logic       in_valid_q;
  logic [7:0] in_filt_q, in_above_q, in_type_q;
  logic       in_last_q;
  logic       out_valid_q;
  logic [7:0] out_data_q;
  logic       out_last_q;
  logic       advance;
  logic [7:0] recon;
  nbr_t       nbr;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  png_ru_hist u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .bpp_i     (bytes_per_pixel(pixel_bits_q)),
    .recon_i   (recon),
    .above_i   (in_above_q),
    .row_end_i (in_last_q),
    .nbr_o     (nbr)
  );

  png_ru_pred u_pred (
    .filtered_i    (in_filt_q),
    .above_i       (in_above_q),
    .filter_type_i (in_type_q),
    .nbr_i         (nbr),
    .recon_o       (recon)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_bits_q <= PixelBitsReset;
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pixel_bits_q <= cfg_wdata_i;
      end
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_filt_q  <= s_axis_tdata[7:0];
      in_above_q <= s_axis_tdata[15:8];
      in_type_q  <= s_axis_tuser;
      in_last_q  <= s_axis_tlast;
    end
    if (advance) begin
      out_data_q <= recon;
      out_last_q <= in_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// File: rtl/core/png_ru_checker.sv
module png_ru_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast
);

  logic s_beat;
  assign s_beat = s_axis_tvalid && s_axis_tready;

  // A stalled output beat keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output beat changed");

  // With the output empty the input side is always open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked while output empty");

  // An input beat taken while the output is empty shows once it has passed the input and output registers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_beat && !m_axis_tvalid |-> ##2 m_axis_tvalid)
    else $error("output beat missing after input beat");

  // A fresh output beat comes from an earlier input beat that passed the input and output registers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_beat, 2))
    else $error("output beat without matching input beat");

endmodule

bind png_row_unfilter png_ru_checker u_png_ru_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// File: test/png_row_unfilter_tb.sv
module png_row_unfilter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import png_ru_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned RandomBytes = 1700;
  localparam logic [7:0] FiltFirstUnknown = 8'd5;
  localparam logic [7:0] FiltLastUnknown = 8'd255;

  typedef struct packed {
    logic [7:0] recon;
    logic       row_end;
  } recon_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [6:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic [7:0]  s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  recon_beat_t pending_recon[$];
  logic [7:0]  left_bytes[MaxBpp];
  logic [7:0]  upper_left_bytes[MaxBpp];
  int unsigned bytes_into_row;
  logic [6:0]  pixel_bits;
  int unsigned bytes_sent;
  int unsigned mismatch_count;
  int unsigned quiet_cycles;
  int unsigned sink_stall;
  bit          steady;

  png_row_unfilter uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  function automatic int unsigned idle_len();
    int unsigned r;
    if (steady) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_filter();
    if ($urandom_range(0, 99) < 88) begin
      return 8'($urandom_range(FiltNone, FiltPaeth));
    end
    return 8'($urandom_range(FiltFirstUnknown, FiltLastUnknown));
  endfunction

  function automatic int unsigned pixel_bytes();
    int unsigned n;
    n = (int'(pixel_bits) + 7) >> 3;
    if (n < 1) begin
      n = 1;
    end else if (n > MaxBpp) begin
      n = MaxBpp;
    end
    return n;
  endfunction

  function automatic logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    int p, da, db, dc;
    p  = int'(a) + int'(b) - int'(c);
    da = p - int'(a);
    db = p - int'(b);
    dc = p - int'(c);
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    if (da <= db && da <= dc) begin
      return a;
    end else if (db <= dc) begin
      return b;
    end
    return c;
  endfunction

  task automatic unfilter_byte(logic [7:0] filt, logic [7:0] above, logic [7:0] ftype,
                               logic row_end);
    int unsigned bpp;
    logic [7:0]  a, c, pred, recon;
    bpp = pixel_bytes();
    a = 8'd0;
    c = 8'd0;
    if (bytes_into_row >= bpp) begin
      a = left_bytes[bpp-1];
      c = upper_left_bytes[bpp-1];
    end
    case (ftype)
      FiltSub:   pred = a;
      FiltUp:    pred = above;
      FiltAvg:   pred = 8'((9'(a) + 9'(above)) >> 1);
      FiltPaeth: pred = paeth_pick(a, above, c);
      default:   pred = 8'd0;
    endcase
    recon = filt + pred;
    for (int k = MaxBpp - 1; k > 0; k--) begin
      left_bytes[k]       = left_bytes[k-1];
      upper_left_bytes[k] = upper_left_bytes[k-1];
    end
    left_bytes[0]       = recon;
    upper_left_bytes[0] = above;
    if (row_end) begin
      bytes_into_row = 0;
    end else if (bytes_into_row < bpp) begin
      bytes_into_row++;
    end
    pending_recon.push_back('{recon: recon, row_end: row_end});
  endtask

  task automatic report_mismatch(string field, logic [7:0] got, logic [7:0] want);
    mismatch_count++;
    if (mismatch_count <= 50) begin
      $display("%0t: %s mismatch, got %02h, expected %02h", $realtime, field, got, want);
    end
  endtask

  task automatic send_byte(logic [7:0] filt, logic [7:0] above, logic [7:0] ftype,
                           logic row_end);
    int unsigned gap;
    @(negedge clk_i);
    gap = idle_len();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  = {above, filt};
    s_axis_tuser  = ftype;
    s_axis_tlast  = row_end;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    unfilter_byte(filt, above, ftype, row_end);
  endtask

  task automatic stop_input();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    stop_input();
    while (pending_recon.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_pixel_bits(logic [6:0] value);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    pixel_bits  = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic send_row(int unsigned len, logic [7:0] ftype, bit mixed, bit no_above);
    logic [7:0] above;
    for (int unsigned i = 0; i < len; i++) begin
      above = no_above ? 8'd0 : 8'($urandom);
      send_byte(8'($urandom), above, mixed ? pick_filter() : ftype, i == len - 1);
    end
  endtask

  task automatic test_directed();
    send_byte(8'h00, 8'h00, FiltNone, 1'b0);
    send_byte(8'hff, 8'hff, FiltSub, 1'b0);
    send_byte(8'h80, 8'h7f, FiltUp, 1'b0);
    send_byte(8'hff, 8'hff, FiltAvg, 1'b0);
    send_byte(8'h12, 8'h34, FiltPaeth, 1'b0);
    send_byte(8'h55, 8'haa, FiltFirstUnknown, 1'b0);
    send_byte(8'hff, 8'h00, FiltLastUnknown, 1'b1);
    // The first byte of a row sees no left neighbour even after a full row.
    send_byte(8'h01, 8'h10, FiltSub, 1'b0);
    send_byte(8'h01, 8'h10, FiltPaeth, 1'b0);
    send_byte(8'h00, 8'h10, FiltPaeth, 1'b0);
    send_byte(8'hff, 8'h00, FiltAvg, 1'b0);
    send_byte(8'h7f, 8'hff, FiltPaeth, 1'b0);
    send_byte(8'h80, 8'h80, FiltSub, 1'b1);
    send_byte(8'h00, 8'hff, FiltPaeth, 1'b1);
    send_byte(8'haa, 8'h55, FiltAvg, 1'b1);
  endtask

  task automatic test_pixel_widths();
    logic [6:0] widths[16] = '{7'd0, 7'd1, 7'd7, 7'd8, 7'd9, 7'd16, 7'd17, 7'd24,
                               7'd32, 7'd48, 7'd56, 7'd63, 7'd64, 7'd65, 7'd100, 7'd127};
    foreach (widths[i]) begin
      write_pixel_bits(widths[i]);
      send_row($urandom_range(1, 4 * pixel_bytes() + 2), pick_filter(), 1'b0, 1'b0);
      send_row($urandom_range(1, 4 * pixel_bytes() + 2), pick_filter(), 1'b1, 1'b0);
    end
  endtask

  task automatic test_config_mid_row();
    write_pixel_bits(7'd8);
    for (int i = 0; i < 5; i++) begin
      send_byte(8'($urandom), 8'($urandom), FiltPaeth, 1'b0);
    end
    // The new pixel size applies from the next beat on, using the histories as they are.
    write_pixel_bits(7'd24);
    for (int i = 0; i < 6; i++) begin
      send_byte(8'($urandom), 8'($urandom), FiltPaeth, i == 5);
    end
  endtask

  task automatic test_random_rows();
    int unsigned len;
    while (bytes_sent < RandomBytes) begin
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        write_pixel_bits($urandom_range(0, 3) == 0 ? 7'($urandom) : 7'($urandom_range(1, 32)));
      end
      if ($urandom_range(0, 19) == 0) begin
        wait_drained();
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
      send_row(len, pick_filter(), $urandom_range(0, 6) == 0, $urandom_range(0, 9) == 0);
    end
    steady = 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (sink_stall > 0) begin
      m_axis_tready = 1'b0;
      sink_stall--;
    end else begin
      m_axis_tready = 1'b1;
      sink_stall = idle_len();
    end
  end

  always @(posedge clk_i) begin
    recon_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_recon.size() == 0) begin
        report_mismatch("unexpected beat", m_axis_tdata, 8'h00);
      end else begin
        want = pending_recon.pop_front();
        if (m_axis_tdata !== want.recon) begin
          report_mismatch("recon_byte", m_axis_tdata, want.recon);
        end
        if (m_axis_tlast !== want.row_end) begin
          report_mismatch("row_end", 8'(m_axis_tlast), 8'(want.row_end));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = 7'd0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = 16'd0;
    s_axis_tuser   = 8'd0;
    s_axis_tlast   = 1'b0;
    m_axis_tready  = 1'b0;
    sink_stall     = 0;
    steady         = 1'b0;
    quiet_cycles   = 0;
    bytes_sent     = 0;
    mismatch_count = 0;
    bytes_into_row = 0;
    pixel_bits     = PixelBitsReset;
    for (int k = 0; k < MaxBpp; k++) begin
      left_bytes[k]       = 8'd0;
      upper_left_bytes[k] = 8'd0;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_pixel_widths();
    test_config_mid_row();
    test_random_rows();

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/png_ru_pkg.sv
rtl/core/png_ru_pred.sv
rtl/core/png_ru_hist.sv
rtl/core/png_row_unfilter.sv
rtl/core/png_ru_checker.sv
test/png_row_unfilter_tb.sv
